// ----- rtl/core/cr3bp_pkg.sv -----
// Shared constants, types and helpers for the CR3BP force and Jacobi pipeline.
package cr3bp_pkg;

    localparam int FIELD_W     = 32;
    localparam int DATA_WIDTH  = 32;
    localparam int AXES        = 3;
    localparam int LANES       = AXES + 1;
    localparam int MASS_W      = FIELD_W + 1;
    localparam int OFS_W       = FIELD_W + 2;
    localparam int MAG_W       = FIELD_W;
    localparam int RAD_W       = 2 * MAG_W;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int REM_W       = ROOT_W + 2;
    localparam int PROD_W      = RAD_W + ROOT_W;
    localparam int NUM_W       = 64;
    localparam int LEN_W       = 6;
    localparam int PULL_SHIFT  = 45;
    localparam int POT_SHIFT   = 19;
    localparam int NSH_W       = NUM_W + PULL_SHIFT;
    localparam int Q_W         = 41;
    localparam int HI_W        = NSH_W - Q_W;
    localparam int PULL_W      = Q_W + 1;
    localparam int POT_W       = Q_W;
    localparam int LIN_W       = FIELD_W + 2;
    localparam int JB_W        = FIELD_W + 3;
    localparam int MU_FRAC_SH  = 5;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int DIV_STAGES  = Q_W;
    localparam int PRIM_LAT    = SQRT_STAGES + DIV_STAGES + 9;
    localparam int SIDE_DLY    = PRIM_LAT - 2;
    localparam int VLD_DEPTH   = PRIM_LAT + 2;

    localparam logic [Q_W-1:0] TERM_CAP = Q_W'(1) << (Q_W - 1);
    localparam logic signed [63:0] SAT_MAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_MIN = -SAT_MAX - 64'sd1;

    typedef struct packed {
        logic [RAD_W-1:0]            rad;
        logic [REM_W-1:0]            rem;
        logic [ROOT_W-1:0]           root;
        logic [AXES-1:0][NUM_W-1:0]  num;
        logic [AXES-1:0]             neg;
        logic [MASS_W-1:0]           mass;
    } sq_stage_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [Q_W-1:0]   low;
        logic [Q_W-1:0]   quo;
        logic [NUM_W-1:0] dvs;
        logic             ovf;
        logic             zero;
        logic             neg;
    } div_lane_t;

    typedef struct packed {
        logic [AXES-1:0][PULL_W-1:0] pull;
        logic [POT_W-1:0]            pot;
        logic                        clip;
    } prim_res_t;

    typedef struct packed {
        logic [FIELD_W-1:0]      rate_x;
        logic [FIELD_W-1:0]      rate_y;
        logic [FIELD_W-1:0]      rate_z;
        logic signed [LIN_W-1:0] lin_x;
        logic signed [LIN_W-1:0] lin_y;
        logic signed [JB_W-1:0]  jbase;
    } side_t;

    // {clip, value}
    function automatic logic [DATA_WIDTH:0] sat_dw(input logic signed [63:0] v);
        logic [DATA_WIDTH:0] r;
        if (v > SAT_MAX) begin
            r = {1'b1, SAT_MAX[DATA_WIDTH-1:0]};
        end else if (v < SAT_MIN) begin
            r = {1'b1, SAT_MIN[DATA_WIDTH-1:0]};
        end else begin
            r = {1'b0, v[DATA_WIDTH-1:0]};
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/cr3bp_state_if.sv -----
// Input channel: one rotating-frame state per transaction.
interface cr3bp_state_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [cr3bp_pkg::FIELD_W-1:0]       pos_x;
    logic signed [cr3bp_pkg::FIELD_W-1:0]       pos_y;
    logic signed [cr3bp_pkg::FIELD_W-1:0]       pos_z;
    logic signed [cr3bp_pkg::FIELD_W-1:0]       vel_x;
    logic signed [cr3bp_pkg::FIELD_W-1:0]       vel_y;
    logic signed [cr3bp_pkg::FIELD_W-1:0]       vel_z;

    modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

// ----- rtl/core/cr3bp_deriv_if.sv -----
// Output channel: state derivative, Jacobi constant and clip flag per transaction.
interface cr3bp_deriv_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [cr3bp_pkg::FIELD_W-1:0]       rate_x;
    logic signed [cr3bp_pkg::FIELD_W-1:0]       rate_y;
    logic signed [cr3bp_pkg::FIELD_W-1:0]       rate_z;
    logic signed [cr3bp_pkg::DATA_WIDTH-1:0]    accel_x;
    logic signed [cr3bp_pkg::DATA_WIDTH-1:0]    accel_y;
    logic signed [cr3bp_pkg::DATA_WIDTH-1:0]    accel_z;
    logic signed [cr3bp_pkg::DATA_WIDTH-1:0]    jacobi;
    logic                                       saturated;

    modport source (output valid, rate_x, rate_y, rate_z, accel_x, accel_y, accel_z,
                    jacobi, saturated, input ready);
    modport sink   (input valid, rate_x, rate_y, rate_z, accel_x, accel_y, accel_z,
                    jacobi, saturated, output ready);
endinterface

// ----- rtl/core/cr3bp_force_and_jacobi_top.sv -----
// Top level of the CR3BP equations-of-motion and Jacobi constant pipeline.
//
// Usage:
//   state_in  carries one rotating-frame state (pos_*, vel_*, signed Q4.27) per
//             transaction; deriv_out returns the velocity pass-through, the
//             rotating-frame accelerations and the Jacobi constant (Q8.23) and
//             the saturated flag for that state, in order.
//   cfg_wr_en / cfg_wr_data write the mass ratio (unsigned Q0.32); write it
//             only while no transaction is in flight.
//   Throughput is one transaction per cycle unless deriv_out stalls: each
//   primary runs a 32-stage root and 41-stage dividers, one bit per stage,
//   all fully pipelined.
//   Reset clears the mass ratio to zero and empties the pipeline.
//   When deriv_out is stalled with a result waiting, the whole pipeline holds
//   and state_in.ready drops; nothing is lost or repeated.
module cr3bp_force_and_jacobi_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [cr3bp_pkg::FIELD_W-1:0]       cfg_wr_data,
    cr3bp_state_if.sink                         state_in,
    cr3bp_deriv_if.source                       deriv_out
);

    logic                                       en;
    logic [cr3bp_pkg::FIELD_W-1:0]              mass_ratio_reg;
    logic [cr3bp_pkg::VLD_DEPTH-1:0]            vld_reg, vld_next;

    logic signed [cr3bp_pkg::FIELD_W-1:0]       a_x_reg, a_y_reg, a_z_reg;
    logic signed [cr3bp_pkg::FIELD_W-1:0]       a_vx_reg, a_vy_reg, a_vz_reg;

    logic [cr3bp_pkg::FIELD_W:0]                mu_sum;
    logic [cr3bp_pkg::OFS_W-1:0]                mu27;
    logic signed [cr3bp_pkg::OFS_W-1:0]         ofs1, ofs2;
    logic [cr3bp_pkg::MASS_W-1:0]               m1, m2;
    cr3bp_pkg::prim_res_t                       p1, p2;

    logic signed [63:0]                         xx_sq, yy_sq, vxx_sq, vyy_sq, vzz_sq;
    logic [63:0]                                xx_reg, yy_reg, vxx_reg, vyy_reg, vzz_reg;
    logic signed [cr3bp_pkg::LIN_W-1:0]         lin_x_next, lin_y_next;
    logic signed [cr3bp_pkg::LIN_W-1:0]         b_lin_x_reg, b_lin_y_reg;
    logic [cr3bp_pkg::FIELD_W-1:0]              b_vx_reg, b_vy_reg, b_vz_reg;
    logic [63:0]                                pp, vv;
    cr3bp_pkg::side_t                           side_next;
    cr3bp_pkg::side_t                           c_side_reg;
    cr3bp_pkg::side_t                           side_reg [cr3bp_pkg::SIDE_DLY];

    logic signed [63:0]                         acc_x, acc_y, acc_z, jac;
    logic [cr3bp_pkg::DATA_WIDTH:0]             sx, sy, sz, sj;
    logic [cr3bp_pkg::FIELD_W-1:0]              rate_x_reg, rate_y_reg, rate_z_reg;
    logic [cr3bp_pkg::DATA_WIDTH-1:0]           accel_x_reg, accel_y_reg, accel_z_reg;
    logic [cr3bp_pkg::DATA_WIDTH-1:0]           jacobi_reg;
    logic                                       saturated_reg;

    assign en             = !vld_reg[cr3bp_pkg::VLD_DEPTH-1] || deriv_out.ready;
    assign state_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_ratio_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            mass_ratio_reg <= cfg_wr_data;
        end
    end

    assign vld_next = {vld_reg[cr3bp_pkg::VLD_DEPTH-2:0], state_in.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_x_reg  <= state_in.pos_x;
            a_y_reg  <= state_in.pos_y;
            a_z_reg  <= state_in.pos_z;
            a_vx_reg <= state_in.vel_x;
            a_vy_reg <= state_in.vel_y;
            a_vz_reg <= state_in.vel_z;
        end
    end

    // primary offsets and masses
    always_comb
    begin
        mu_sum = {1'b0, mass_ratio_reg} + (cr3bp_pkg::FIELD_W+1)'(16);
        mu27   = cr3bp_pkg::OFS_W'(mu_sum >> cr3bp_pkg::MU_FRAC_SH);
        ofs1   = cr3bp_pkg::OFS_W'(a_x_reg) + mu27;
        ofs2   = cr3bp_pkg::OFS_W'(a_x_reg) - (cr3bp_pkg::OFS_W'(1) << 27) + mu27;
        m1     = (cr3bp_pkg::MASS_W'(1) << cr3bp_pkg::FIELD_W) - {1'b0, mass_ratio_reg};
        m2     = {1'b0, mass_ratio_reg};
    end

    cr3bp_prim u_prim1 (
        .clk   (clk),
        .en    (en),
        .mass  (m1),
        .ofs   (ofs1),
        .pos_y (a_y_reg),
        .pos_z (a_z_reg),
        .res   (p1)
    );

    cr3bp_prim u_prim2 (
        .clk   (clk),
        .en    (en),
        .mass  (m2),
        .ofs   (ofs2),
        .pos_y (a_y_reg),
        .pos_z (a_z_reg),
        .res   (p2)
    );

    // linear terms and squares
    always_comb
    begin
        xx_sq  = a_x_reg * a_x_reg;
        yy_sq  = a_y_reg * a_y_reg;
        vxx_sq = a_vx_reg * a_vx_reg;
        vyy_sq = a_vy_reg * a_vy_reg;
        vzz_sq = a_vz_reg * a_vz_reg;
        lin_x_next = ((cr3bp_pkg::LIN_W'(a_vy_reg) <<< 1) + cr3bp_pkg::LIN_W'(a_x_reg)) >>> 4;
        lin_y_next = (cr3bp_pkg::LIN_W'(a_y_reg) - (cr3bp_pkg::LIN_W'(a_vx_reg) <<< 1)) >>> 4;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg      <= xx_sq;
            yy_reg      <= yy_sq;
            vxx_reg     <= vxx_sq;
            vyy_reg     <= vyy_sq;
            vzz_reg     <= vzz_sq;
            b_lin_x_reg <= lin_x_next;
            b_lin_y_reg <= lin_y_next;
            b_vx_reg    <= a_vx_reg;
            b_vy_reg    <= a_vy_reg;
            b_vz_reg    <= a_vz_reg;
        end
    end

    always_comb
    begin
        pp = xx_reg + yy_reg;
        vv = vxx_reg + vyy_reg + vzz_reg;
        side_next.rate_x = b_vx_reg;
        side_next.rate_y = b_vy_reg;
        side_next.rate_z = b_vz_reg;
        side_next.lin_x  = b_lin_x_reg;
        side_next.lin_y  = b_lin_y_reg;
        side_next.jbase  = $signed({2'b00, pp[63:31]}) - $signed({2'b00, vv[63:31]});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_side_reg <= side_next;
            side_reg[0] <= c_side_reg;
            for (int i = 1; i < cr3bp_pkg::SIDE_DLY; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // combine and saturate
    always_comb
    begin
        cr3bp_pkg::side_t s;
        s = side_reg[cr3bp_pkg::SIDE_DLY-1];
        acc_x = 64'(s.lin_x)
                - $signed({{(64-cr3bp_pkg::PULL_W){p1.pull[0][cr3bp_pkg::PULL_W-1]}}, p1.pull[0]})
                - $signed({{(64-cr3bp_pkg::PULL_W){p2.pull[0][cr3bp_pkg::PULL_W-1]}}, p2.pull[0]});
        acc_y = 64'(s.lin_y)
                - $signed({{(64-cr3bp_pkg::PULL_W){p1.pull[1][cr3bp_pkg::PULL_W-1]}}, p1.pull[1]})
                - $signed({{(64-cr3bp_pkg::PULL_W){p2.pull[1][cr3bp_pkg::PULL_W-1]}}, p2.pull[1]});
        acc_z = 64'sd0
                - $signed({{(64-cr3bp_pkg::PULL_W){p1.pull[2][cr3bp_pkg::PULL_W-1]}}, p1.pull[2]})
                - $signed({{(64-cr3bp_pkg::PULL_W){p2.pull[2][cr3bp_pkg::PULL_W-1]}}, p2.pull[2]});
        jac   = 64'(s.jbase)
                + $signed({{(64-cr3bp_pkg::POT_W){1'b0}}, p1.pot})
                + $signed({{(64-cr3bp_pkg::POT_W){1'b0}}, p2.pot});
        sx = cr3bp_pkg::sat_dw(acc_x);
        sy = cr3bp_pkg::sat_dw(acc_y);
        sz = cr3bp_pkg::sat_dw(acc_z);
        sj = cr3bp_pkg::sat_dw(jac);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rate_x_reg    <= side_reg[cr3bp_pkg::SIDE_DLY-1].rate_x;
            rate_y_reg    <= side_reg[cr3bp_pkg::SIDE_DLY-1].rate_y;
            rate_z_reg    <= side_reg[cr3bp_pkg::SIDE_DLY-1].rate_z;
            accel_x_reg   <= sx[cr3bp_pkg::DATA_WIDTH-1:0];
            accel_y_reg   <= sy[cr3bp_pkg::DATA_WIDTH-1:0];
            accel_z_reg   <= sz[cr3bp_pkg::DATA_WIDTH-1:0];
            jacobi_reg    <= sj[cr3bp_pkg::DATA_WIDTH-1:0];
            saturated_reg <= p1.clip | p2.clip | sx[cr3bp_pkg::DATA_WIDTH]
                             | sy[cr3bp_pkg::DATA_WIDTH] | sz[cr3bp_pkg::DATA_WIDTH]
                             | sj[cr3bp_pkg::DATA_WIDTH];
        end
    end

    assign deriv_out.valid     = vld_reg[cr3bp_pkg::VLD_DEPTH-1];
    assign deriv_out.rate_x    = rate_x_reg;
    assign deriv_out.rate_y    = rate_y_reg;
    assign deriv_out.rate_z    = rate_z_reg;
    assign deriv_out.accel_x   = accel_x_reg;
    assign deriv_out.accel_y   = accel_y_reg;
    assign deriv_out.accel_z   = accel_z_reg;
    assign deriv_out.jacobi    = jacobi_reg;
    assign deriv_out.saturated = saturated_reg;

endmodule

// ----- rtl/core/cr3bp_prim.sv -----
// Pipelined pull and potential of one primary: squares, root, normalize, capped dividers.
module cr3bp_prim (
    input  logic                                    clk,
    input  logic                                    en,
    input  logic [cr3bp_pkg::MASS_W-1:0]            mass,
    input  logic signed [cr3bp_pkg::OFS_W-1:0]      ofs,
    input  logic signed [cr3bp_pkg::FIELD_W-1:0]    pos_y,
    input  logic signed [cr3bp_pkg::FIELD_W-1:0]    pos_z,
    output cr3bp_pkg::prim_res_t                    res
);

    // stage 1: magnitudes and squares
    logic [cr3bp_pkg::AXES-1:0][cr3bp_pkg::MAG_W-1:0] mag_next, mag_reg;
    logic [cr3bp_pkg::AXES-1:0][cr3bp_pkg::RAD_W-1:0] sq_next, sq_reg;
    logic [cr3bp_pkg::AXES-1:0]                        neg_next, neg_reg;
    logic [cr3bp_pkg::MASS_W-1:0]                      mass_reg;
    logic signed [cr3bp_pkg::AXES-1:0][cr3bp_pkg::OFS_W-1:0] comp;

    // sqrt chain, index 0 is the sum stage
    cr3bp_pkg::sq_stage_t sq_next_a [cr3bp_pkg::SQRT_STAGES+1];
    cr3bp_pkg::sq_stage_t sq_stage_reg [cr3bp_pkg::SQRT_STAGES+1];

    // product and normalize
    logic [cr3bp_pkg::RAD_W-1:0]                       lo_next, lo_reg, mid_next, mid_reg;
    logic [cr3bp_pkg::ROOT_W-1:0]                      mul_root_reg, add_root_reg;
    logic [cr3bp_pkg::ROOT_W-1:0]                      lz_root_reg, shf_root_reg;
    logic [cr3bp_pkg::AXES-1:0][cr3bp_pkg::NUM_W-1:0] mul_num_reg, add_num_reg;
    logic [cr3bp_pkg::AXES-1:0][cr3bp_pkg::NUM_W-1:0] lz_num_reg, shf_num_reg;
    logic [cr3bp_pkg::AXES-1:0]                        mul_neg_reg, add_neg_reg;
    logic [cr3bp_pkg::AXES-1:0]                        lz_neg_reg, shf_neg_reg;
    logic [cr3bp_pkg::MASS_W-1:0]                      mul_mass_reg, add_mass_reg;
    logic [cr3bp_pkg::MASS_W-1:0]                      lz_mass_reg, shf_mass_reg;
    logic [cr3bp_pkg::PROD_W-1:0]                      prod_next, prod_reg, lz_prod_reg;
    logic [cr3bp_pkg::LEN_W-1:0]                       len_next, len_reg;
    logic [cr3bp_pkg::NUM_W-1:0]                       dn_next, dn_reg;
    logic [cr3bp_pkg::LEN_W-1:0]                       sh_next, sh_reg;
    logic [cr3bp_pkg::PROD_W-1:0]                      prod_sh;

    // dividend alignment
    logic [cr3bp_pkg::LANES-1:0][cr3bp_pkg::HI_W-1:0]  hi_next, hi_reg;
    logic [cr3bp_pkg::LANES-1:0][cr3bp_pkg::Q_W-1:0]   low_next, low_reg;
    logic [cr3bp_pkg::LANES-1:0][cr3bp_pkg::NUM_W-1:0] dvs_next, dvs_reg;
    logic [cr3bp_pkg::LANES-1:0]                       zero_next, zero_reg;
    logic [cr3bp_pkg::LANES-1:0]                       nneg_next, nneg_reg;
    logic [cr3bp_pkg::NSH_W-1:0]                       nsh;

    // divider chain, index 0 is the compare stage
    cr3bp_pkg::div_lane_t dv_next [cr3bp_pkg::DIV_STAGES+1][cr3bp_pkg::LANES];
    cr3bp_pkg::div_lane_t dv_reg  [cr3bp_pkg::DIV_STAGES+1][cr3bp_pkg::LANES];

    cr3bp_pkg::prim_res_t res_next, res_reg;

    // ---------------- stage 1
    always_comb
    begin
        logic [cr3bp_pkg::OFS_W-1:0] a;
        comp[0] = ofs;
        comp[1] = cr3bp_pkg::OFS_W'(pos_y);
        comp[2] = cr3bp_pkg::OFS_W'(pos_z);
        for (int i = 0; i < cr3bp_pkg::AXES; i++)
        begin
            a           = comp[i][cr3bp_pkg::OFS_W-1] ? cr3bp_pkg::OFS_W'(-comp[i]) : comp[i];
            mag_next[i] = a[cr3bp_pkg::MAG_W-1:0];
            neg_next[i] = comp[i][cr3bp_pkg::OFS_W-1];
            sq_next[i]  = cr3bp_pkg::RAD_W'(mag_next[i]) * cr3bp_pkg::RAD_W'(mag_next[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg  <= mag_next;
            sq_reg   <= sq_next;
            neg_reg  <= neg_next;
            mass_reg <= mass;
        end
    end

    // ---------------- stage 2: radius squared (wraps) and pull numerators
    always_comb
    begin
        logic [cr3bp_pkg::MASS_W+cr3bp_pkg::MAG_W-1:0] np;
        sq_next_a[0]      = '0;
        sq_next_a[0].rad  = sq_reg[0] + sq_reg[1] + sq_reg[2];
        sq_next_a[0].neg  = neg_reg;
        sq_next_a[0].mass = mass_reg;
        for (int i = 0; i < cr3bp_pkg::AXES; i++)
        begin
            np = mass_reg * mag_reg[i];
            sq_next_a[0].num[i] = np[cr3bp_pkg::NUM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_stage_reg[0] <= sq_next_a[0];
        end
    end

    // ---------------- integer square root, one result bit per stage
    for (genvar j = 0; j < cr3bp_pkg::SQRT_STAGES; j++)
    begin : g_sqrt
        always_comb
        begin
            logic [cr3bp_pkg::REM_W+1:0] t;
            logic [cr3bp_pkg::REM_W-1:0] trial;
            sq_next_a[j+1] = sq_stage_reg[j];
            t     = {sq_stage_reg[j].rem,
                     sq_stage_reg[j].rad[cr3bp_pkg::RAD_W-1-2*j -: 2]};
            trial = {sq_stage_reg[j].root, 2'b01};
            if (t >= {2'b00, trial})
            begin
                sq_next_a[j+1].rem  = cr3bp_pkg::REM_W'(t - {2'b00, trial});
                sq_next_a[j+1].root = {sq_stage_reg[j].root[cr3bp_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sq_next_a[j+1].rem  = t[cr3bp_pkg::REM_W-1:0];
                sq_next_a[j+1].root = {sq_stage_reg[j].root[cr3bp_pkg::ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_stage_reg[j+1] <= sq_next_a[j+1];
            end
        end
    end

    // ---------------- product S*R as two partial products, then add
    always_comb
    begin
        lo_next  = cr3bp_pkg::RAD_W'(sq_stage_reg[cr3bp_pkg::SQRT_STAGES].rad[31:0])
                   * cr3bp_pkg::RAD_W'(sq_stage_reg[cr3bp_pkg::SQRT_STAGES].root);
        mid_next = cr3bp_pkg::RAD_W'(sq_stage_reg[cr3bp_pkg::SQRT_STAGES].rad[63:32])
                   * cr3bp_pkg::RAD_W'(sq_stage_reg[cr3bp_pkg::SQRT_STAGES].root);
        prod_next = {mid_reg, 32'b0} + cr3bp_pkg::PROD_W'(lo_reg);
        len_next = '0;
        for (int b = 0; b < cr3bp_pkg::PROD_W - cr3bp_pkg::RAD_W; b++)
        begin
            if (prod_reg[cr3bp_pkg::RAD_W+b])
            begin
                len_next = cr3bp_pkg::LEN_W'(b + 1);
            end
        end
        prod_sh = lz_prod_reg >> len_reg;
        dn_next = prod_sh[cr3bp_pkg::NUM_W-1:0];
        sh_next = cr3bp_pkg::LEN_W'(cr3bp_pkg::PULL_SHIFT) - len_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg       <= lo_next;
            mid_reg      <= mid_next;
            mul_root_reg <= sq_stage_reg[cr3bp_pkg::SQRT_STAGES].root;
            mul_num_reg  <= sq_stage_reg[cr3bp_pkg::SQRT_STAGES].num;
            mul_neg_reg  <= sq_stage_reg[cr3bp_pkg::SQRT_STAGES].neg;
            mul_mass_reg <= sq_stage_reg[cr3bp_pkg::SQRT_STAGES].mass;

            prod_reg     <= prod_next;
            add_root_reg <= mul_root_reg;
            add_num_reg  <= mul_num_reg;
            add_neg_reg  <= mul_neg_reg;
            add_mass_reg <= mul_mass_reg;

            len_reg      <= len_next;
            lz_prod_reg  <= prod_reg;
            lz_root_reg  <= add_root_reg;
            lz_num_reg   <= add_num_reg;
            lz_neg_reg   <= add_neg_reg;
            lz_mass_reg  <= add_mass_reg;

            dn_reg       <= dn_next;
            sh_reg       <= sh_next;
            shf_root_reg <= lz_root_reg;
            shf_num_reg  <= lz_num_reg;
            shf_neg_reg  <= lz_neg_reg;
            shf_mass_reg <= lz_mass_reg;
        end
    end

    // ---------------- dividend alignment: lanes 0..2 pulls, lane 3 potential
    always_comb
    begin
        for (int i = 0; i < cr3bp_pkg::LANES; i++)
        begin
            if (i < cr3bp_pkg::AXES)
            begin
                nsh          = cr3bp_pkg::NSH_W'(shf_num_reg[i]) << sh_reg;
                dvs_next[i]  = dn_reg;
                zero_next[i] = (shf_num_reg[i] == '0);
                nneg_next[i] = shf_neg_reg[i];
            end
            else
            begin
                nsh          = cr3bp_pkg::NSH_W'(shf_mass_reg) << cr3bp_pkg::POT_SHIFT;
                dvs_next[i]  = cr3bp_pkg::NUM_W'(shf_root_reg);
                zero_next[i] = (shf_mass_reg == '0);
                nneg_next[i] = 1'b0;
            end
            hi_next[i]  = nsh[cr3bp_pkg::NSH_W-1:cr3bp_pkg::Q_W];
            low_next[i] = nsh[cr3bp_pkg::Q_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi_reg   <= hi_next;
            low_reg  <= low_next;
            dvs_reg  <= dvs_next;
            zero_reg <= zero_next;
            nneg_reg <= nneg_next;
        end
    end

    // quotient overflow check
    always_comb
    begin
        for (int i = 0; i < cr3bp_pkg::LANES; i++)
        begin
            dv_next[0][i].rem  = hi_reg[i][cr3bp_pkg::NUM_W-1:0];
            dv_next[0][i].low  = low_reg[i];
            dv_next[0][i].quo  = '0;
            dv_next[0][i].dvs  = dvs_reg[i];
            dv_next[0][i].ovf  = (hi_reg[i] >= cr3bp_pkg::HI_W'(dvs_reg[i]));
            dv_next[0][i].zero = zero_reg[i];
            dv_next[0][i].neg  = nneg_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < cr3bp_pkg::LANES; i++)
            begin
                dv_reg[0][i] <= dv_next[0][i];
            end
        end
    end

    // ---------------- restoring division, one quotient bit per stage
    for (genvar j = 0; j < cr3bp_pkg::DIV_STAGES; j++)
    begin : g_div
        always_comb
        begin
            logic [cr3bp_pkg::NUM_W:0] t;
            logic                      ge;
            for (int i = 0; i < cr3bp_pkg::LANES; i++)
            begin
                dv_next[j+1][i] = dv_reg[j][i];
                t  = {dv_reg[j][i].rem, dv_reg[j][i].low[cr3bp_pkg::Q_W-1]};
                ge = (t >= {1'b0, dv_reg[j][i].dvs});
                dv_next[j+1][i].rem = ge ? cr3bp_pkg::NUM_W'(t - {1'b0, dv_reg[j][i].dvs})
                                         : t[cr3bp_pkg::NUM_W-1:0];
                dv_next[j+1][i].low = {dv_reg[j][i].low[cr3bp_pkg::Q_W-2:0], 1'b0};
                dv_next[j+1][i].quo = {dv_reg[j][i].quo[cr3bp_pkg::Q_W-2:0], ge};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < cr3bp_pkg::LANES; i++)
                begin
                    dv_reg[j+1][i] <= dv_next[j+1][i];
                end
            end
        end
    end

    // ---------------- cap, sign and pack
    always_comb
    begin
        cr3bp_pkg::div_lane_t     l;
        logic                     big;
        logic [cr3bp_pkg::Q_W-1:0] v;
        res_next = '0;
        for (int i = 0; i < cr3bp_pkg::LANES; i++)
        begin
            l   = dv_reg[cr3bp_pkg::DIV_STAGES][i];
            big = l.ovf || (l.quo > cr3bp_pkg::TERM_CAP);
            if (l.zero)
            begin
                v = '0;
            end
            else if (big)
            begin
                v = cr3bp_pkg::TERM_CAP;
            end
            else
            begin
                v = l.quo;
            end
            if (!l.zero && big)
            begin
                res_next.clip = 1'b1;
            end
            if (i < cr3bp_pkg::AXES)
            begin
                res_next.pull[i] = l.neg ? cr3bp_pkg::PULL_W'(-{1'b0, v}) : {1'b0, v};
            end
            else
            begin
                res_next.pot = v;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule
